>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define PCQ_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// same check on the block clock and reset
`define PCQ_ASSERT_CLK(lbl, prop, msg) \
	`PCQ_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

>>> src/pcq_pkg.sv
`timescale 1ns / 1ps

package pcq_pkg;

	localparam int DELTA_W = 9;
	localparam int ACC_W   = 10;
	localparam int POS_W   = 10;
	localparam int SIZE_W  = 11;
	localparam int BTN_W   = 3;
	localparam int PEND_W  = 5;
	localparam int SUM_W   = 12;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 56;

	localparam int SCALE_TEXT_SHIFT = 3;

	localparam logic [SIZE_W-1:0] TEXT_WIDTH_LIMIT = 11'd80;
	localparam logic [SIZE_W-1:0] POS_LIMIT        = 11'd1024;
	localparam logic [SIZE_W-1:0] WIDTH_RESET      = 11'd80;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET     = 11'd25;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] CMD_DEPTH = 2'd2;

	typedef enum logic [1:0] {
		EVT_MOVE = 2'd0,
		EVT_DOWN = 2'd1,
		EVT_UP   = 2'd2
	} evt_kind_t;

	typedef struct packed {
		evt_kind_t        kind;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [BTN_W-1:0] button;
	} event_t;

	// push_mask: bit0 move, bits 1..3 buttons 0..2
	typedef struct packed {
		logic             pop;
		logic [3:0]       push_mask;
		logic [BTN_W-1:0] buttons;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		evt_kind_t         kind;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [BTN_W-1:0]  button;
		logic [POS_W-1:0]  cur_col;
		logic [POS_W-1:0]  cur_row;
		logic [BTN_W-1:0]  buttons;
		logic [PEND_W-1:0] pending;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PUSH,
		BK_EMIT
	} back_state_t;

endpackage

>>> src/pcq_front.sv
`timescale 1ns / 1ps

module pcq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_opcode,
	input  logic signed [pcq_pkg::DELTA_W-1:0] in_dx,
	input  logic signed [pcq_pkg::DELTA_W-1:0] in_dy,
	input  logic [pcq_pkg::BTN_W-1:0]   in_buttons,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [pcq_pkg::SIZE_W-1:0]  cfg_data,
	input  logic [1:0]                  fifo_count,
	output logic                        cmd_push,
	output pcq_pkg::cmd_t               cmd
);

	function automatic logic signed [pcq_pkg::ACC_W-1:0] div_text(
		input logic signed [pcq_pkg::ACC_W-1:0] a
	);
		logic [pcq_pkg::ACC_W-1:0] mag;
		logic [pcq_pkg::ACC_W-1:0] q;
		mag = a[pcq_pkg::ACC_W-1] ? (~a + 1'b1) : a;
		q   = mag >> pcq_pkg::SCALE_TEXT_SHIFT;
		return a[pcq_pkg::ACC_W-1] ? $signed(~q + 1'b1) : $signed(q);
	endfunction

	function automatic logic [pcq_pkg::SIZE_W-1:0] bound_of(
		input logic [pcq_pkg::SIZE_W-1:0] size
	);
		return (size > pcq_pkg::POS_LIMIT) ? pcq_pkg::POS_LIMIT : size;
	endfunction

	function automatic logic [pcq_pkg::POS_W-1:0] clamp_pos(
		input logic signed [pcq_pkg::SUM_W-1:0] p,
		input logic [pcq_pkg::SIZE_W-1:0]       lim
	);
		logic [pcq_pkg::SIZE_W-1:0] top;
		top = lim - 1'b1;
		if (p[pcq_pkg::SUM_W-1]) begin
			return '0;
		end else if (p[pcq_pkg::SIZE_W-1:0] >= lim) begin
			return top[pcq_pkg::POS_W-1:0];
		end else begin
			return p[pcq_pkg::POS_W-1:0];
		end
	endfunction

	logic [pcq_pkg::SIZE_W-1:0]       width_q, height_q;
	logic signed [pcq_pkg::ACC_W-1:0] accx_q, accy_q;
	logic [pcq_pkg::POS_W-1:0]        pos_col_q, pos_row_q;
	logic [pcq_pkg::BTN_W-1:0]        held_q;

	logic                             valid_s1;
	logic                             pop_s1;
	logic signed [pcq_pkg::ACC_W-1:0] cdx_s1, cdy_s1;
	logic [3:0]                       mask_s1;
	logic [pcq_pkg::BTN_W-1:0]        btn_s1;

	logic                             accept;
	logic                             text_mode;
	logic signed [pcq_pkg::ACC_W-1:0] sum_x, sum_y, q_x, q_y, rem_x, rem_y;
	logic                             moved;
	logic [pcq_pkg::BTN_W-1:0]        changed;
	logic signed [pcq_pkg::SUM_W-1:0] col_sum, row_sum;
	logic [pcq_pkg::POS_W-1:0]        new_col, new_row;
	logic [pcq_pkg::SIZE_W-1:0]       eff_w, eff_h;
	logic [pcq_pkg::POS_W-1:0]        cfg_col, cfg_row;

	assign in_ready = ({1'b0, valid_s1} + fifo_count) < pcq_pkg::CMD_DEPTH;
	assign accept   = in_valid && in_ready;

	// accumulate and split into whole cells and remainder
	always_comb begin
		text_mode = width_q <= pcq_pkg::TEXT_WIDTH_LIMIT;
		sum_x     = accx_q + {in_dx[pcq_pkg::DELTA_W-1], in_dx};
		sum_y     = accy_q + {in_dy[pcq_pkg::DELTA_W-1], in_dy};
		q_x       = text_mode ? div_text(sum_x) : sum_x;
		q_y       = text_mode ? div_text(sum_y) : sum_y;
		rem_x     = text_mode ? (sum_x - (q_x <<< pcq_pkg::SCALE_TEXT_SHIFT)) : '0;
		rem_y     = text_mode ? (sum_y - (q_y <<< pcq_pkg::SCALE_TEXT_SHIFT)) : '0;
		moved     = (q_x != '0) || (q_y != '0);
		changed   = in_buttons ^ held_q;
	end

	// cursor move and clamp
	always_comb begin
		col_sum = $signed({2'b00, pos_col_q}) + {{2{cdx_s1[pcq_pkg::ACC_W-1]}}, cdx_s1};
		row_sum = $signed({2'b00, pos_row_q}) + {{2{cdy_s1[pcq_pkg::ACC_W-1]}}, cdy_s1};
		new_col = clamp_pos(col_sum, bound_of(width_q));
		new_row = clamp_pos(row_sum, bound_of(height_q));
	end

	// bounds write re-clamps against the new bounds
	always_comb begin
		eff_w = ((cfg_index == pcq_pkg::REG_SCREEN_WIDTH) && (cfg_data != '0)) ?
			cfg_data : width_q;
		eff_h = ((cfg_index == pcq_pkg::REG_SCREEN_HEIGHT) && (cfg_data != '0)) ?
			cfg_data : height_q;
		cfg_col = clamp_pos($signed({2'b00, pos_col_q}), bound_of(eff_w));
		cfg_row = clamp_pos($signed({2'b00, pos_row_q}), bound_of(eff_h));
	end

	always_comb begin
		cmd_push       = valid_s1;
		cmd.pop        = pop_s1;
		cmd.push_mask  = pop_s1 ? 4'b0000 : mask_s1;
		cmd.buttons    = pop_s1 ? held_q : btn_s1;
		cmd.col        = pop_s1 ? pos_col_q : new_col;
		cmd.row        = pop_s1 ? pos_row_q : new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			width_q   <= pcq_pkg::WIDTH_RESET;
			height_q  <= pcq_pkg::HEIGHT_RESET;
			accx_q    <= '0;
			accy_q    <= '0;
			pos_col_q <= '0;
			pos_row_q <= '0;
			held_q    <= '0;
		end else begin
			valid_s1 <= accept;
			priority if (cfg_we) begin
				unique case (cfg_index)
					pcq_pkg::REG_SCREEN_WIDTH: begin
						if (cfg_data != '0) width_q <= cfg_data;
					end
					pcq_pkg::REG_SCREEN_HEIGHT: begin
						if (cfg_data != '0) height_q <= cfg_data;
					end
				endcase
				accx_q    <= '0;
				accy_q    <= '0;
				pos_col_q <= cfg_col;
				pos_row_q <= cfg_row;
			end else begin
				if (accept && (in_opcode == pcq_pkg::OP_PACKET)) begin
					accx_q <= rem_x;
					accy_q <= rem_y;
					held_q <= in_buttons;
				end
				if (valid_s1 && (pop_s1 == pcq_pkg::OP_PACKET)) begin
					pos_col_q <= new_col;
					pos_row_q <= new_row;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1  <= in_opcode;
			cdx_s1  <= q_x;
			cdy_s1  <= q_y;
			mask_s1 <= {changed, moved};
			btn_s1  <= in_buttons;
		end
	end

endmodule

>>> src/pcq_cmd_fifo.sv
`timescale 1ns / 1ps

module pcq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcq_pkg::cmd_t wdata,
	input  logic          pop,
	output pcq_pkg::cmd_t rdata,
	output logic          not_empty,
	output logic [1:0]    count
);

	pcq_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;

	assign rdata     = entry_q[rd_ptr_q];
	assign not_empty = cnt_q != 2'd0;
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> src/pcq_back.sv
`timescale 1ns / 1ps

module pcq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  pcq_pkg::cmd_t    cmd,
	output logic             cmd_take,
	output logic             out_valid,
	input  logic             out_ready,
	output pcq_pkg::result_t out_data
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end else begin
			return s + 1'b1;
		end
	endfunction

	pcq_pkg::event_t      mem_q [QUEUE_DEPTH];
	pcq_pkg::back_state_t state_q, state_d;
	logic [SLOT_W-1:0]    wr_slot_q, rd_slot_q;
	logic [FILL_W-1:0]    fill_q;
	logic [3:0]           mask_q;
	logic                 got_q;
	pcq_pkg::cmd_t        cmd_q;
	pcq_pkg::event_t      rd_q;
	logic                 out_valid_q;
	pcq_pkg::result_t     out_q;

	logic                 full;
	logic                 rd_en, push_en, load_out;
	logic [3:0]           pick;
	logic [3:0]           mask_left;
	pcq_pkg::event_t      evt;
	pcq_pkg::result_t     res;

	assign full      = fill_q == FILL_W'(QUEUE_DEPTH);
	assign mask_left = mask_q & ~pick;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcq_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.pop || (cmd.push_mask == 4'b0000)) ?
						pcq_pkg::BK_EMIT : pcq_pkg::BK_PUSH;
				end
			end
			pcq_pkg::BK_PUSH: begin
				if (mask_left == 4'b0000) state_d = pcq_pkg::BK_EMIT;
			end
			pcq_pkg::BK_EMIT: begin
				if (load_out) state_d = pcq_pkg::BK_IDLE;
			end
			default: state_d = pcq_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = (state_q == pcq_pkg::BK_IDLE) && cmd_valid;
		rd_en    = cmd_take && cmd.pop && (fill_q != '0);
		push_en  = state_q == pcq_pkg::BK_PUSH;
		load_out = (state_q == pcq_pkg::BK_EMIT) && (!out_valid_q || out_ready);
	end

	// one event a cycle, move first, then buttons 0, 1, 2
	always_comb begin
		pick       = 4'b0000;
		evt.kind   = pcq_pkg::EVT_MOVE;
		evt.col    = cmd_q.col;
		evt.row    = cmd_q.row;
		evt.button = 3'b000;
		priority if (mask_q[0]) begin
			pick = 4'b0001;
		end else if (mask_q[1]) begin
			pick       = 4'b0010;
			evt.kind   = cmd_q.buttons[0] ? pcq_pkg::EVT_DOWN : pcq_pkg::EVT_UP;
			evt.button = 3'b001;
		end else if (mask_q[2]) begin
			pick       = 4'b0100;
			evt.kind   = cmd_q.buttons[1] ? pcq_pkg::EVT_DOWN : pcq_pkg::EVT_UP;
			evt.button = 3'b010;
		end else if (mask_q[3]) begin
			pick       = 4'b1000;
			evt.kind   = cmd_q.buttons[2] ? pcq_pkg::EVT_DOWN : pcq_pkg::EVT_UP;
			evt.button = 3'b100;
		end else begin
			pick = 4'b0000;
		end
	end

	always_comb begin
		res.valid   = got_q;
		res.kind    = got_q ? rd_q.kind : pcq_pkg::EVT_MOVE;
		res.col     = got_q ? rd_q.col : '0;
		res.row     = got_q ? rd_q.row : '0;
		res.button  = got_q ? rd_q.button : '0;
		res.cur_col = cmd_q.col;
		res.cur_row = cmd_q.row;
		res.buttons = cmd_q.buttons;
		res.pending = pcq_pkg::PEND_W'(fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcq_pkg::BK_IDLE;
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			fill_q      <= '0;
			mask_q      <= 4'b0000;
			got_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_take) begin
				mask_q <= cmd.pop ? 4'b0000 : cmd.push_mask;
				got_q  <= rd_en;
			end else if (push_en) begin
				mask_q <= mask_left;
			end
			if (rd_en) begin
				rd_slot_q <= next_slot(rd_slot_q);
				fill_q    <= fill_q - 1'b1;
			end
			if (push_en) begin
				wr_slot_q <= next_slot(wr_slot_q);
				if (full) begin
					rd_slot_q <= next_slot(rd_slot_q);
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)  mem_q[wr_slot_q] <= evt;
		if (rd_en)    rd_q <= mem_q[rd_slot_q];
		if (cmd_take) cmd_q <= cmd;
		if (load_out) out_q <= res;
	end

endmodule

>>> src/pointer_cursor_event_queue_top.sv
`timescale 1ns / 1ps

// Pointer cursor and event queue. A word on the slave side is either a pointer
// packet (signed dx, dy and button bits) or a pop request; each one gives exactly
// one result word with the popped event (if any), the cursor, the held buttons and
// the queue fill. The front end takes a word, works out cell movement and button
// changes, registers them and hands a command through a two-entry queue to the back
// end, which owns the event store: a packet queues n (0 to 4) events, one store
// write per cycle, and a pop does one registered store read and then loads the
// output register. The event store has no reset; a pop only reads entries written
// before. Bounds are to be written only while no word is in flight; the block
// itself does not enforce it. A write clears the accumulators and pulls the cursor
// back inside the screen.
module pointer_cursor_event_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// delta_x[8:0], delta_y[17:9], button_bits[20:18]
	input  logic [pcq_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_kind[1:0], event_col[11:2], event_row[21:12], event_button[24:22],
	// cursor_col[34:25], cursor_row[44:35], button_state[47:45],
	// pending_events[52:48]
	output logic [pcq_pkg::M_TDATA_W-1:0]     m_tdata,
	// event_valid
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pcq_pkg::SIZE_W-1:0]        cfg_data
);

	logic             cmd_push, cmd_valid, cmd_take;
	logic [1:0]       fifo_count;
	pcq_pkg::cmd_t    cmd_in, cmd_out;
	pcq_pkg::result_t res;

	pcq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_opcode  (s_tuser),
		.in_dx      ($signed(s_tdata[8:0])),
		.in_dy      ($signed(s_tdata[17:9])),
		.in_buttons (s_tdata[20:18]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fifo_count (fifo_count),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	pcq_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.wdata     (cmd_in),
		.pop       (cmd_take),
		.rdata     (cmd_out),
		.not_empty (cmd_valid),
		.count     (fifo_count)
	);

	pcq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tuser = res.valid;
	assign m_tdata = {3'b000, res.pending, res.buttons, res.cur_row, res.cur_col,
		res.button, res.row, res.col, res.kind};

endmodule

>>> src/pcq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pcq_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	`PCQ_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped")
	`PCQ_ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled word changed")
	`PCQ_ASSERT_CLK(a_no_event_zero, m_tvalid && !m_tuser |-> m_tdata[24:0] == 25'd0, "event fields set without event")
	`PCQ_ASSERT_CLK(a_event_code, m_tvalid && m_tuser |-> (m_tdata[1:0] == 2'd0 && m_tdata[24:22] == 3'd0) || ((m_tdata[1:0] == 2'd1 || m_tdata[1:0] == 2'd2) && (m_tdata[24:22] == 3'd1 || m_tdata[24:22] == 3'd2 || m_tdata[24:22] == 3'd4)), "bad event kind or button")

endmodule

bind pointer_cursor_event_queue_top pcq_checker u_pcq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
